FILE: rtl/ipv6_hop_option_rewriter_assert.svh
// Assertion macros for the IPv6 hop-by-hop option rewriter.
// Used by the top level; needs clock and reset in scope.
`ifndef IPV6_HOP_OPTION_REWRITER_ASSERT_SVH
`define IPV6_HOP_OPTION_REWRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define IHOR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define IHOR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IHOR_ASSERT_IMPL(lbl, ante, cons, msg)
`define IHOR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/ihor_pkg.sv
// Types, codes and helpers shared by the hop-by-hop option rewriter.
// No dependencies.
package ihor_pkg;

   localparam int BASE_HEADER_BYTES = 40;
   localparam int HOP_HEADER_BYTES  = 24;
   localparam int STORE_BYTES       = BASE_HEADER_BYTES + 4;
   localparam int OUT_DEPTH         = 4;

   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_CUST_HI  = 2'd1;
   localparam logic [1:0] REG_CUST_LO  = 2'd2;
   localparam logic [1:0] REG_OPT_KIND = 2'd3;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_STRIP  = 2'd2;
   localparam logic [1:0] MODE_PASS   = 2'd3;

   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_ADDED     = 3'd1;
   localparam logic [2:0] ACT_UPDATED   = 3'd2;
   localparam logic [2:0] ACT_REPLACED  = 3'd3;
   localparam logic [2:0] ACT_STRIPPED  = 3'd4;
   localparam logic [2:0] ACT_UNCHANGED = 3'd5;
   localparam logic [2:0] ACT_BAD       = 3'd6;
   localparam logic [2:0] ACT_OVERSIZE  = 3'd7;

   localparam logic [2:0] ST_BAD = 3'd5;

   localparam logic [7:0] CUSTODY_DATA_BYTES = 8'd16;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_BYTE,
      CMD_STORED,
      CMD_HEADER
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] cust_hi;
      logic [63:0] cust_lo;
      logic [7:0]  opt_kind;
   } cfg_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [2:0]  status;
      logic        custodian_found;
      logic [63:0] old_custodian_high;
      logic [63:0] old_custodian_low;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [5:0] addr;
      logic [7:0] data;
   } store_wr_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [5:0]   last_idx;
      logic [15:0]  plen;
      logic [7:0]   nh;
      logic         fresh;
      logic [7:0]   fnext;
      logic         end_pkt;
      logic [2:0]   status;
      logic         found;
      logic [63:0]  hi;
      logic [63:0]  lo;
   } cmd_type;

   function automatic logic [7:0] cust_byte(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [3:0] i);
      logic [5:0] base;
      base = {3'd7 - i[2:0], 3'b000};
      return i[3] ? lo[base +: 8] : hi[base +: 8];
   endfunction

endpackage

FILE: rtl/ihor_front.sv
// Front end: accepts packet beats, tracks position and decides the rewrite.
// Depends on ihor_pkg; issues commands to the back end queue.
module ihor_front
   import ihor_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   input  req_type      req_data,
   output logic         full,
   input  logic         cq_full,
   input  logic         burst_done,
   output logic         cmd_push,
   output cmd_type      cmd,
   output store_wr_type store_wr
);

   logic [15:0] pos_ff, pos_in;
   logic [11:0] skip_ff, skip_in;
   logic [2:0]  act_ff, act_in;
   logic        found_ff, found_in;
   logic [63:0] addr_hi_ff, addr_hi_in, addr_lo_ff, addr_lo_in;
   logic [7:0]  sh4_ff, sh5_ff, sh6_ff, h40_ff, h41_ff, h42_ff, h43_ff;
   logic [7:0]  h40_in, h41_in, h42_in, h43_in;
   logic        wait_ff, wait_in;

   logic        accept;
   logic [15:0] p;
   logic [7:0]  b;
   logic        eop;
   logic [15:0] plen;
   logic [11:0] hl;
   logic [16:0] np_add, rep17;
   logic        strip_bad;
   logic [15:0] plen_strip;
   logic [5:0]  p_idx;

   assign full   = cq_full | wait_ff;
   assign accept = push & ~full;
   assign p      = pos_ff;
   assign b      = req_data.packet_byte;
   assign eop    = req_data.end_of_packet;
   assign p_idx  = (p < 16'(STORE_BYTES)) ? p[5:0] : 6'(STORE_BYTES - 1);

   assign store_wr.en   = accept & (p < 16'(STORE_BYTES));
   assign store_wr.addr = p[5:0];
   assign store_wr.data = b;

   assign h40_in = (p == 16'd40) ? b : h40_ff;
   assign h41_in = (p == 16'd41) ? b : h41_ff;
   assign h42_in = (p == 16'd42) ? b : h42_ff;
   assign h43_in = (p == 16'd43) ? b : h43_ff;

   assign plen       = {sh4_ff, sh5_ff};
   assign hl         = {({1'b0, h41_in} + 9'd1), 3'b000};
   assign np_add     = {1'b0, plen} + 17'(HOP_HEADER_BYTES);
   assign strip_bad  = plen < {4'd0, hl};
   assign plen_strip = plen - {4'd0, hl};
   assign rep17      = {1'b0, plen_strip} + 17'(HOP_HEADER_BYTES);

   always_comb begin
      addr_hi_in = addr_hi_ff;
      addr_lo_in = addr_lo_ff;
      found_in   = found_ff;
      if (p >= 16'(STORE_BYTES) && p < 16'(STORE_BYTES + 16) && sh6_ff == 8'd0) begin
         if (p < 16'(STORE_BYTES + 8)) addr_hi_in = {addr_hi_ff[55:0], b};
         else addr_lo_in = {addr_lo_ff[55:0], b};
      end
      if (p == 16'(STORE_BYTES + 15))
         found_in = (sh6_ff == 8'd0) && (h42_ff == cfg.opt_kind)
                    && (h43_ff == CUSTODY_DATA_BYTES);
   end

   always_comb begin
      cmd      = '0;
      cmd.kind = CMD_NONE;
      act_in   = act_ff;
      skip_in  = skip_ff;
      pos_in   = pos_ff;
      if (act_ff == ACT_NONE) begin
         if (p == 16'(BASE_HEADER_BYTES - 1)) begin
            if (cfg.mode == MODE_PASS || (cfg.mode == MODE_STRIP && sh6_ff != 8'd0)) begin
               act_in       = ACT_UNCHANGED;
               cmd.kind     = CMD_STORED;
               cmd.last_idx = p_idx;
            end else if (cfg.mode == MODE_ADD || (cfg.mode == MODE_UPDATE && sh6_ff != 8'd0)) begin
               if (np_add[16]) begin
                  act_in       = ACT_OVERSIZE;
                  cmd.kind     = CMD_STORED;
                  cmd.last_idx = p_idx;
               end else begin
                  act_in    = ACT_ADDED;
                  cmd.kind  = CMD_HEADER;
                  cmd.plen  = np_add[15:0];
                  cmd.nh    = 8'd0;
                  cmd.fresh = 1'b1;
                  cmd.fnext = sh6_ff;
               end
            end
         end else if (sh6_ff == 8'd0 && cfg.mode == MODE_STRIP && p == 16'd41) begin
            if (strip_bad) begin
               act_in       = ACT_BAD;
               cmd.kind     = CMD_STORED;
               cmd.last_idx = p_idx;
            end else begin
               act_in   = ACT_STRIPPED;
               cmd.kind = CMD_HEADER;
               cmd.plen = plen_strip;
               cmd.nh   = h40_in;
               skip_in  = hl - 12'd2;
            end
         end else if (sh6_ff == 8'd0 && cfg.mode == MODE_UPDATE && p == 16'd43) begin
            if (h42_in == cfg.opt_kind && h43_in == CUSTODY_DATA_BYTES) begin
               act_in       = ACT_UPDATED;
               cmd.kind     = CMD_STORED;
               cmd.last_idx = p_idx;
            end else if (strip_bad) begin
               act_in       = ACT_BAD;
               cmd.kind     = CMD_STORED;
               cmd.last_idx = p_idx;
            end else if (rep17[16]) begin
               act_in       = ACT_OVERSIZE;
               cmd.kind     = CMD_STORED;
               cmd.last_idx = p_idx;
            end else begin
               act_in    = ACT_REPLACED;
               cmd.kind  = CMD_HEADER;
               cmd.plen  = rep17[15:0];
               cmd.nh    = 8'd0;
               cmd.fresh = 1'b1;
               cmd.fnext = h40_in;
               skip_in   = hl - 12'd4;
            end
         end
      end else if (skip_ff != 12'd0) begin
         skip_in = skip_ff - 12'd1;
      end else if (act_ff == ACT_UPDATED && p >= 16'(STORE_BYTES)
                   && p < 16'(STORE_BYTES + 16)) begin
         cmd.kind = CMD_BYTE;
         cmd.data = cust_byte(cfg.cust_hi, cfg.cust_lo, 4'(p - 16'(STORE_BYTES)));
      end else begin
         cmd.kind = CMD_BYTE;
         cmd.data = b;
      end

      if (eop) begin
         if (act_in == ACT_NONE) begin
            act_in       = ACT_BAD;
            cmd.kind     = CMD_STORED;
            cmd.last_idx = p_idx;
         end
         cmd.end_pkt = 1'b1;
         cmd.status  = act_in - 3'd1;
         if ((act_in == ACT_REPLACED || act_in == ACT_STRIPPED) && skip_in != 12'd0)
            cmd.status = ST_BAD;
         if (act_in == ACT_UPDATED && p < 16'(STORE_BYTES + 15))
            cmd.status = ST_BAD;
         cmd.found = found_in;
         cmd.hi    = found_in ? addr_hi_in : 64'd0;
         cmd.lo    = found_in ? addr_lo_in : 64'd0;
         pos_in    = 16'd0;
         skip_in   = 12'd0;
         act_in    = ACT_NONE;
      end else if (p != 16'hFFFF) begin
         pos_in = p + 16'd1;
      end
   end

   assign cmd_push = accept & ((cmd.kind != CMD_NONE) | eop);

   always_comb begin
      wait_in = wait_ff;
      if (burst_done) wait_in = 1'b0;
      if (cmd_push && (cmd.kind == CMD_STORED || cmd.kind == CMD_HEADER)) wait_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         skip_ff    <= '0;
         act_ff     <= ACT_NONE;
         found_ff   <= 1'b0;
         addr_hi_ff <= '0;
         addr_lo_ff <= '0;
         wait_ff    <= 1'b0;
      end else begin
         wait_ff <= wait_in;
         if (accept) begin
            pos_ff  <= pos_in;
            skip_ff <= skip_in;
            act_ff  <= act_in;
            if (eop) begin
               found_ff   <= 1'b0;
               addr_hi_ff <= '0;
               addr_lo_ff <= '0;
            end else begin
               found_ff   <= found_in;
               addr_hi_ff <= addr_hi_in;
               addr_lo_ff <= addr_lo_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (p == 16'd4) sh4_ff <= b;
         if (p == 16'd5) sh5_ff <= b;
         if (p == 16'd6) sh6_ff <= b;
         h40_ff <= h40_in;
         h41_ff <= h41_in;
         h42_ff <= h42_in;
         h43_ff <= h43_in;
      end
   end

endmodule

FILE: rtl/ihor_cmd_queue.sv
// Two-entry command queue between front and back end.
// Depends on ihor_pkg.
module ihor_cmd_queue
   import ihor_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_push,
   input  cmd_type cmd,
   output logic    cq_full,
   input  logic    cq_pop,
   output logic    cq_valid,
   output cmd_type cq_head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign cq_full  = count_ff == 2'd2;
   assign cq_valid = count_ff != 2'd0;
   assign cq_head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (cmd_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (cq_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, cmd_push} - {1'b0, cq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_push) entry_ff[wr_ptr_ff] <= cmd;
   end

endmodule

FILE: rtl/ihor_back.sv
// Back end: header buffer, byte sequencer, one-byte hold and result queue.
// Depends on ihor_pkg; consumes commands from ihor_cmd_queue.
module ihor_back
   import ihor_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  store_wr_type store_wr,
   input  logic         cq_valid,
   input  cmd_type      cq_head,
   output logic         cq_pop,
   output logic         burst_done,
   input  logic         pop,
   output logic         empty,
   output rsp_type      rsp_data
);

   logic [7:0] store_mem [STORE_BYTES];
   logic [7:0] rd_ff;
   logic [5:0] rd_addr;

   logic [5:0] idx_ff, idx_in;
   logic       fin_ff, fin_in;

   logic       s2_valid_ff, s2_fin_ff, s2_mem_ff;
   logic [7:0] s2_lit_ff;
   logic [2:0] s2_status_ff;
   logic       s2_found_ff;
   logic [63:0] s2_hi_ff, s2_lo_ff;

   logic       held_valid_ff;
   logic [7:0] held_ff;

   rsp_type    ofifo_ff [OUT_DEPTH];
   logic [1:0] owr_ff, ord_ff;
   logic [2:0] ocount_ff;

   logic       issue, byte_phase, use_mem, op_fin;
   logic [5:0] limit;
   logic [7:0] lit;
   logic [4:0] j;
   logic       opush;
   rsp_type    odata;
   logic [7:0] cur_byte;

   assign issue      = cq_valid && ((ocount_ff + {2'd0, s2_valid_ff}) < 3'(OUT_DEPTH));
   assign byte_phase = !fin_ff && cq_head.kind != CMD_NONE;
   assign j          = 5'(idx_ff - 6'(BASE_HEADER_BYTES));

   always_comb begin
      unique case (cq_head.kind)
         CMD_BYTE:   limit = 6'd0;
         CMD_STORED: limit = cq_head.last_idx;
         CMD_HEADER: limit = cq_head.fresh ? 6'(BASE_HEADER_BYTES + HOP_HEADER_BYTES - 1)
                                           : 6'(BASE_HEADER_BYTES - 1);
         default:    limit = 6'd0;
      endcase
   end

   always_comb begin
      use_mem = 1'b0;
      lit     = 8'd0;
      unique case (cq_head.kind)
         CMD_BYTE:   lit = cq_head.data;
         CMD_STORED: use_mem = 1'b1;
         CMD_HEADER: begin
            if (idx_ff == 6'd4) lit = cq_head.plen[15:8];
            else if (idx_ff == 6'd5) lit = cq_head.plen[7:0];
            else if (idx_ff == 6'd6) lit = cq_head.nh;
            else if (idx_ff < 6'(BASE_HEADER_BYTES)) use_mem = 1'b1;
            else if (j == 5'd0) lit = cq_head.fnext;
            else if (j == 5'd1) lit = 8'(HOP_HEADER_BYTES / 8 - 1);
            else if (j == 5'd2) lit = cfg.opt_kind;
            else if (j == 5'd3) lit = CUSTODY_DATA_BYTES;
            else if (j < 5'd20) lit = cust_byte(cfg.cust_hi, cfg.cust_lo, 4'(j - 5'd4));
            else lit = 8'd0;
         end
         default: lit = 8'd0;
      endcase
   end

   assign rd_addr = use_mem ? idx_ff : 6'd0;

   always_comb begin
      idx_in     = idx_ff;
      fin_in     = fin_ff;
      cq_pop     = 1'b0;
      burst_done = 1'b0;
      op_fin     = 1'b0;
      if (issue) begin
         if (byte_phase) begin
            if (idx_ff == limit) begin
               idx_in = 6'd0;
               if (cq_head.end_pkt) begin
                  fin_in = 1'b1;
               end else begin
                  cq_pop     = 1'b1;
                  burst_done = cq_head.kind == CMD_STORED || cq_head.kind == CMD_HEADER;
               end
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end else begin
            op_fin     = 1'b1;
            cq_pop     = 1'b1;
            fin_in     = 1'b0;
            burst_done = cq_head.kind == CMD_STORED || cq_head.kind == CMD_HEADER;
         end
      end
   end

   assign cur_byte = s2_mem_ff ? rd_ff : s2_lit_ff;
   assign opush    = s2_valid_ff && (s2_fin_ff || held_valid_ff);

   always_comb begin
      odata          = '0;
      odata.out_byte = held_ff;
      if (s2_fin_ff) begin
         odata.out_last           = 1'b1;
         odata.status             = s2_status_ff;
         odata.custodian_found    = s2_found_ff;
         odata.old_custodian_high = s2_hi_ff;
         odata.old_custodian_low  = s2_lo_ff;
      end
   end

   assign empty    = ocount_ff == 3'd0;
   assign rsp_data = ofifo_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
      rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         fin_ff        <= 1'b0;
         s2_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         owr_ff        <= '0;
         ord_ff        <= '0;
         ocount_ff     <= '0;
      end else begin
         idx_ff      <= idx_in;
         fin_ff      <= fin_in;
         s2_valid_ff <= issue;
         if (s2_valid_ff) held_valid_ff <= !s2_fin_ff;
         if (opush) owr_ff <= owr_ff + 2'd1;
         if (pop && !empty) ord_ff <= ord_ff + 2'd1;
         ocount_ff <= ocount_ff + {2'd0, opush} - {2'd0, pop && !empty};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_fin_ff    <= op_fin;
         s2_mem_ff    <= use_mem && !op_fin;
         s2_lit_ff    <= lit;
         s2_status_ff <= cq_head.status;
         s2_found_ff  <= cq_head.found;
         s2_hi_ff     <= cq_head.hi;
         s2_lo_ff     <= cq_head.lo;
      end
      if (s2_valid_ff && !s2_fin_ff) held_ff <= cur_byte;
      if (opush) ofifo_ff[owr_ff] <= odata;
   end

endmodule

FILE: rtl/ipv6_hop_option_rewriter.sv
// Top level of the IPv6 hop-by-hop custody option rewriter.
// Depends on ihor_pkg, ihor_front, ihor_cmd_queue, ihor_back and the assert header.
//
// Packet bytes stream in and out at one beat per clock unless full or a
// result-side stall holds them. Output lags input by one byte so the final
// beat can carry out_last and the status fields. At the decision point (byte
// 39, 41 or 43) the buffered header, and a fresh 24-byte hop-by-hop header
// when one is added, is replayed one byte per cycle, with full high during
// the replay and until the packet is closed if it ends on the decision byte.
// A packet that ends before its decision point replays its stored bytes at
// its end, holding full meanwhile. The back end closes each packet in a step
// of its own, so the two-entry command queue can fill and hold full near
// packet ends. Result-side stalls stretch all of these. The burst rate is set
// by the single read port of the header buffer. No clearing pass after reset.
// Configuration must be written only while the block is idle (not enforced).
module ipv6_hop_option_rewriter
   import ihor_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  req_type     req_data,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

`include "ipv6_hop_option_rewriter_assert.svh"

   cfg_type      cfg_ff;
   store_wr_type store_wr;
   logic         cq_full, cq_pop, cq_valid, cmd_push, burst_done;
   logic         burst_push;
   cmd_type      cmd, cq_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_UPDATE;
         cfg_ff.cust_hi  <= '0;
         cfg_ff.cust_lo  <= '0;
         cfg_ff.opt_kind <= 8'd30;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MODE:     cfg_ff.mode     <= csr_data[1:0];
            REG_CUST_HI:  cfg_ff.cust_hi  <= csr_data;
            REG_CUST_LO:  cfg_ff.cust_lo  <= csr_data;
            REG_OPT_KIND: cfg_ff.opt_kind <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   ihor_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .cq_full    (cq_full),
      .burst_done (burst_done),
      .cmd_push   (cmd_push),
      .cmd        (cmd),
      .store_wr   (store_wr)
   );

   ihor_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd_push (cmd_push),
      .cmd      (cmd),
      .cq_full  (cq_full),
      .cq_pop   (cq_pop),
      .cq_valid (cq_valid),
      .cq_head  (cq_head)
   );

   ihor_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .store_wr   (store_wr),
      .cq_valid   (cq_valid),
      .cq_head    (cq_head),
      .cq_pop     (cq_pop),
      .burst_done (burst_done),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

   assign burst_push = cmd_push && (cmd.kind == CMD_STORED || cmd.kind == CMD_HEADER);

   `IHOR_ASSERT_IMPL(a_cmd_no_overflow, cmd_push, !cq_full, "command pushed into full queue")
   `IHOR_ASSERT_IMPL(a_burst_done_waits, burst_done, full, "burst done while front not held")
   `IHOR_ASSERT_NEXT(a_burst_holds_input, burst_push, full, "input not held during burst")

endmodule

FILE: tb/tb_top.sv
// Testbench for ipv6_hop_option_rewriter: packets go in byte by byte, and the rewritten
// packet bytes and end-of-packet status come back and are compared with a local rewrite model.
// Depends on ihor_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
   import ihor_pkg::*;

   logic        clock;
   logic        reset;
   logic        push;
   req_type     req_data;
   logic        full;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   ipv6_hop_option_rewriter i_dut (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data), .full(full),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // rewrite model state
   logic [1:0]  m_mode;
   logic [63:0] m_cust_hi, m_cust_lo;
   logic [7:0]  m_kind;
   logic [7:0]  hdr [0:STORE_BYTES-1];
   int          pos, skip_left;
   logic [2:0]  act;
   logic        found;
   logic [63:0] found_addr [0:1];
   logic        held_vld;
   logic [7:0]  held;

   req_type pending_beats [$];
   rsp_type expected_beats [$];
   int      errors, mismatches, beats_in, beats_out, packets_out, idle_cycles;
   bit      no_gaps, stim_done;
   bit      in_taken;
   int      status_seen [0:7];

   function automatic logic [7:0] node_byte(int i);
      return i < 8 ? m_cust_hi[56-8*i +: 8] : m_cust_lo[56-8*(i-8) +: 8];
   endfunction

   task automatic clear_pkt();
      for (int i = 0; i < STORE_BYTES; i++) hdr[i] = 8'd0;
      pos = 0; skip_left = 0; act = ACT_NONE; found = 1'b0;
      found_addr[0] = '0; found_addr[1] = '0; held_vld = 1'b0; held = '0;
   endtask

   task automatic out_byte(logic [7:0] b);
      rsp_type r;
      if (held_vld) begin
         r = '0;
         r.out_byte = held;
         expected_beats.push_back(r);
      end
      held_vld = 1'b1;
      held = b;
   endtask

   task automatic replay_hdr(int last);
      if (last >= STORE_BYTES) last = STORE_BYTES - 1;
      for (int i = 0; i <= last; i++) out_byte(hdr[i]);
   endtask

   task automatic base_hdr(logic [7:0] nh, logic [31:0] plen);
      for (int i = 0; i < BASE_HEADER_BYTES; i++)
         out_byte(i == 4 ? plen[15:8] : i == 5 ? plen[7:0] : i == 6 ? nh : hdr[i]);
   endtask

   task automatic fresh_hop(logic [7:0] nxt);
      out_byte(nxt);
      out_byte(8'(HOP_HEADER_BYTES / 8 - 1));
      out_byte(m_kind);
      out_byte(CUSTODY_DATA_BYTES);
      for (int i = 0; i < 16; i++) out_byte(node_byte(i));
      for (int i = 20; i < HOP_HEADER_BYTES; i++) out_byte(8'd0);
   endtask

   task automatic decide_rewrite(int p);
      logic [7:0]  nh;
      logic [31:0] plen, hl;
      nh = hdr[6];
      plen = {16'd0, hdr[4], hdr[5]};
      hl = (32'(hdr[BASE_HEADER_BYTES+1]) + 1) * 8;
      if (p == BASE_HEADER_BYTES - 1) begin
         if (m_mode == MODE_PASS || (m_mode == MODE_STRIP && nh != 0)) begin
            act = ACT_UNCHANGED;
            replay_hdr(p);
         end else if (m_mode == MODE_ADD || (m_mode == MODE_UPDATE && nh != 0)) begin
            if (plen + HOP_HEADER_BYTES > 65535) begin
               act = ACT_OVERSIZE;
               replay_hdr(p);
            end else begin
               act = ACT_ADDED;
               base_hdr(8'd0, plen + HOP_HEADER_BYTES);
               fresh_hop(nh);
            end
         end
      end else if (nh == 0) begin
         if (m_mode == MODE_STRIP && p == BASE_HEADER_BYTES + 1) begin
            if (plen < hl) begin
               act = ACT_BAD;
               replay_hdr(p);
            end else begin
               act = ACT_STRIPPED;
               base_hdr(hdr[BASE_HEADER_BYTES], plen - hl);
               skip_left = hl - 2;
            end
         end else if (m_mode == MODE_UPDATE && p == BASE_HEADER_BYTES + 3) begin
            if (hdr[BASE_HEADER_BYTES+2] == m_kind
                && hdr[BASE_HEADER_BYTES+3] == CUSTODY_DATA_BYTES)
            begin
               act = ACT_UPDATED;
               replay_hdr(p);
            end else if (plen < hl) begin
               act = ACT_BAD;
               replay_hdr(p);
            end else if (plen - hl + HOP_HEADER_BYTES > 65535) begin
               act = ACT_OVERSIZE;
               replay_hdr(p);
            end else begin
               act = ACT_REPLACED;
               base_hdr(8'd0, plen - hl + HOP_HEADER_BYTES);
               fresh_hop(hdr[BASE_HEADER_BYTES]);
               skip_left = hl - 4;
            end
         end
      end
   endtask

   task automatic predict_beat(req_type q);
      logic [7:0] b;
      int         p, k;
      rsp_type    r;
      logic [2:0] st;
      b = q.packet_byte;
      p = pos;
      if (p < STORE_BYTES) hdr[p] = b;
      if (p >= STORE_BYTES && p < STORE_BYTES + 16 && hdr[6] == 0) begin
         k = (p - STORE_BYTES) < 8 ? 0 : 1;
         found_addr[k] = {found_addr[k][55:0], b};
      end
      if (p == STORE_BYTES + 15)
         found = hdr[6] == 0 && hdr[BASE_HEADER_BYTES+2] == m_kind &&
                 hdr[BASE_HEADER_BYTES+3] == CUSTODY_DATA_BYTES;
      if (act == ACT_NONE) decide_rewrite(p);
      else if (skip_left > 0) skip_left--;
      else if (act == ACT_UPDATED && p >= STORE_BYTES && p < STORE_BYTES + 16)
         out_byte(node_byte(p - STORE_BYTES));
      else out_byte(b);
      if (q.end_of_packet) begin
         if (act == ACT_NONE) begin
            replay_hdr(p);
            act = ACT_BAD;
         end
         st = act - 3'd1;
         if ((act == ACT_REPLACED || act == ACT_STRIPPED) && skip_left > 0) st = ST_BAD;
         if (act == ACT_UPDATED && p < STORE_BYTES + 15) st = ST_BAD;
         r = '0;
         r.out_byte = held;
         r.out_last = 1'b1;
         r.status = st;
         r.custodian_found = found;
         r.old_custodian_high = found ? found_addr[0] : '0;
         r.old_custodian_low = found ? found_addr[1] : '0;
         expected_beats.push_back(r);
         clear_pkt();
      end else if (p < 65535) begin
         pos = p + 1;
      end
   endtask

   // driver
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
         gap_left = 0;
      end else if (!push || in_taken) begin
         if (push) beats_in++;
         if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 7);
            push <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats[0];
            predict_beat(pending_beats.pop_front());
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver stalls
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 7);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      in_taken = !reset && push && !full;
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (pop && !empty) begin
            beats_out++;
            if (expected_beats.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected beat %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_beats.pop_front();
               if (rsp_data !== e) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("beat %0d mismatch: expected %p, got %p", beats_out, e, rsp_data);
               end
               if (e.out_last) begin
                  packets_out++;
                  status_seen[e.status]++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles > 5000) begin
         $display("timeout: no beat moved for %0d cycles", idle_cycles);
         $display("** ipv6_hop_option_rewriter: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_MODE:     m_mode = val[1:0];
         REG_CUST_HI:  m_cust_hi = val;
         REG_CUST_LO:  m_cust_lo = val;
         REG_OPT_KIND: m_kind = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || push || expected_beats.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one packet: nh is base next header; hop gives the hop header shape
   task automatic queue_packet(int total, logic [7:0] nh, logic [15:0] plen,
                               logic [7:0] hop_len, logic [7:0] kind, logic [7:0] dlen,
                               bit rnd);
      req_type q;
      for (int i = 0; i < total; i++) begin
         q.packet_byte = rnd ? 8'($urandom) : 8'(i);
         if (i == 6) q.packet_byte = nh;
         if (i == 4) q.packet_byte = plen[15:8];
         if (i == 5) q.packet_byte = plen[7:0];
         if (i == 41) q.packet_byte = hop_len;
         if (i == 42) q.packet_byte = kind;
         if (i == 43) q.packet_byte = dlen;
         q.end_of_packet = (i == total - 1);
         pending_beats.push_back(q);
      end
   endtask

   task automatic random_packet();
      int         total, r;
      logic [7:0] nh, hl, kind, dlen;
      logic [15:0] plen;
      r = $urandom_range(0, 99);
      total = r < 20 ? $urandom_range(1, 45) : $urandom_range(44, 64);
      nh = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'd0;
      hl = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
      kind = $urandom_range(0, 2) == 0 ? 8'($urandom) : m_kind;
      dlen = $urandom_range(0, 3) == 0 ? 8'($urandom) : CUSTODY_DATA_BYTES;
      plen = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
      if ($urandom_range(0, 19) == 0) plen = 16'hFFFF - 16'($urandom_range(0, 30));
      queue_packet(total, nh, plen, hl, kind, dlen, 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = REG_MODE;
      csr_data = '0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      m_mode = MODE_UPDATE;
      m_cust_hi = '0;
      m_cust_lo = '0;
      m_kind = 8'd30;
      clear_pkt();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      write_reg(REG_CUST_HI, 64'h2001_0db8_0000_0001);
      write_reg(REG_CUST_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_packet(60, 8'd0, 16'd24, 8'd2, 8'd30, 8'd16, 1'b0);
      queue_packet(41, 8'd17, 16'd10, 8'd0, 8'd0, 8'd0, 1'b0);
      drain();
      write_reg(REG_MODE, 64'(MODE_STRIP));
      queue_packet(48, 8'd0, 16'd30, 8'd0, 8'd30, 8'd16, 1'b0);
      drain();

      // random phases over modes and register values
      for (int ph = 0; ph < 2; ph++) begin
         write_reg(REG_MODE, 64'($urandom_range(0, 3)));
         write_reg(REG_CUST_HI, {$urandom, $urandom});
         write_reg(REG_CUST_LO, {$urandom, $urandom});
         write_reg(REG_OPT_KIND, 64'(ph == 1 ? 8'hFF : 8'($urandom)));
         if (ph == 1) no_gaps = 1'b1;
         random_packet();
         drain();
      end
      $display("%0d beats in, %0d beats and %0d packets out", beats_in, beats_out, packets_out);
      $display("status counts: add %0d upd %0d repl %0d strip %0d same %0d bad %0d big %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("** ipv6_hop_option_rewriter: PASSED **");
      end else begin
         $display("%0d mismatches, %0d beats still expected", errors, expected_beats.size());
         $display("** ipv6_hop_option_rewriter: FAILED **");
      end
      $finish;
   end
endmodule
